// File: design/json_string_unescape_utf8_top_defines.svh
// Assertion macros shared by the checker of the JSON string unescaper.
// No dependencies; each checker that asserts includes this header.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define JSU_ASSERT_NEXT_NR(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/jsu_pkg.sv
// Shared types, character codes and helpers for the JSON string unescaper.
// No dependencies; used by every module of the block.
package jsu_pkg;

  // Decoder modes; unused codes behave as awaiting the opening quote.
  typedef enum logic [2:0] {
    MODE_OPEN = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_DROP = 3'd4
  } jsu_mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } jsu_status_t;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  // Control bytes produced by the single-character escapes.
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // UTF-8 lead and continuation marks.
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;

  localparam logic [1:0] HEX_LAST = 2'd3;

  // Decoder state carried from one item to the next.
  typedef struct packed {
    jsu_mode_t   mode;
    logic [1:0]  hex_count;
    logic [15:0] code_point;
    logic        hex_stopped;
  } jsu_state_t;

  localparam jsu_state_t STATE_RESET = '{
    mode: MODE_OPEN, hex_count: 2'd0, code_point: 16'd0, hex_stopped: 1'b0
  };

  // One result item.
  typedef struct packed {
    logic [7:0]  data;
    jsu_status_t status;
  } jsu_result_t;

  // All results of one input item: count (0 to 3) and the entries in order.
  typedef struct packed {
    logic [1:0]             n;
    jsu_result_t [2:0]      res;
  } jsu_bundle_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      r = {1'b1, d[3:0]};
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      d = c - CH_LOW_A + 8'd10;
      r = {1'b1, d[3:0]};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + 8'd10;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// File: design/json_string_unescape_utf8_top.sv
// JSON string unescaper with UTF-8 output: one byte of a quoted literal per
// item in, decoded bytes and one status result per literal out. An item is
// taken into an input register, decoded combinationally against the literal
// state and its results (none to three) placed in a result buffer that
// drives the result channel, so the first result of an item is shown once it
// has passed the input register and the result buffer. The block takes one
// item per cycle as long as each item yields at most one result and the
// result channel does not stall; an item that yields two or three results
// (as the last hex digit of a \u escape can) holds the byte-wide result
// buffer until each has been taken, so the next item that has a result
// waits in the input register and the input stalls meanwhile.
// Depends on jsu_pkg, jsu_decode and jsu_outbuf.
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_run_last
);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_last_r;
  logic                 adv;
  logic                 load;
  logic                 buf_free;
  jsu_pkg::jsu_bundle_t bundle;

  // The input register refills whenever its item moves on.
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  jsu_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_byte  (s1_byte_r),
    .s1_last  (s1_last_r),
    .buf_free (buf_free),
    .adv      (adv),
    .load     (load),
    .bundle   (bundle)
  );

  jsu_outbuf u_outbuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .bundle       (bundle),
    .buf_free     (buf_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_run_last (out_run_last)
  );

endmodule

// File: design/jsu_decode.sv
// Decoder: holds the literal state and turns one registered byte into its
// results (up to three). Depends on jsu_pkg.
module jsu_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  logic [7:0]          s1_byte,
  input  logic                s1_last,
  input  logic                buf_free,
  output logic                adv,
  output logic                load,
  output jsu_pkg::jsu_bundle_t bundle
);

  jsu_pkg::jsu_state_t st_r;
  jsu_pkg::jsu_state_t st_nxt;
  logic [4:0]          hv;
  logic                take_digit;
  logic [15:0]         cp_upd;
  logic                bad;

  // Next state and results for the byte in the input register.
  always_comb begin
    hv         = jsu_pkg::hex_digit(s1_byte);
    take_digit = !st_r.hex_stopped && hv[4];
    cp_upd     = take_digit ? {st_r.code_point[11:0], hv[3:0]} : st_r.code_point;
    st_nxt     = st_r;
    bundle     = '0;
    bad        = 1'b0;

    unique case (st_r.mode)
      jsu_pkg::MODE_BODY: begin
        if (s1_last) begin
          bundle.n             = 2'd1;
          bundle.res[0].status = (s1_byte == jsu_pkg::CH_QUOTE) ?
                                 jsu_pkg::ST_GOOD : jsu_pkg::ST_BAD;
        end else if (s1_byte == jsu_pkg::CH_BSLASH) begin
          st_nxt.mode = jsu_pkg::MODE_ESC;
        end else begin
          bundle.n           = 2'd1;
          bundle.res[0].data = s1_byte;
        end
      end

      jsu_pkg::MODE_ESC: begin
        if (s1_last) begin
          bad = 1'b1;
        end else begin
          st_nxt.mode = jsu_pkg::MODE_BODY;
          bundle.n    = 2'd1;
          unique case (s1_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
              bundle.res[0].data = s1_byte;
            end
            jsu_pkg::CH_LOW_B: bundle.res[0].data = jsu_pkg::BYTE_BS;
            jsu_pkg::CH_LOW_F: bundle.res[0].data = jsu_pkg::BYTE_FF;
            jsu_pkg::CH_LOW_N: bundle.res[0].data = jsu_pkg::BYTE_LF;
            jsu_pkg::CH_LOW_R: bundle.res[0].data = jsu_pkg::BYTE_CR;
            jsu_pkg::CH_LOW_T: bundle.res[0].data = jsu_pkg::BYTE_HT;
            jsu_pkg::CH_LOW_U: begin
              bundle.n           = 2'd0;
              st_nxt.mode        = jsu_pkg::MODE_HEX;
              st_nxt.hex_count   = 2'd0;
              st_nxt.code_point  = 16'd0;
              st_nxt.hex_stopped = 1'b0;
            end
            default: begin
              bundle.n = 2'd0;
              bad      = 1'b1;
            end
          endcase
        end
      end

      jsu_pkg::MODE_HEX: begin
        if (s1_last) begin
          bad = 1'b1;
        end else begin
          st_nxt.code_point = cp_upd;
          if (!take_digit) begin
            st_nxt.hex_stopped = 1'b1;
          end
          if (st_r.hex_count == jsu_pkg::HEX_LAST) begin
            // Fourth character: emit the code point as UTF-8.
            if (cp_upd[15:7] == 9'd0) begin
              bundle.n           = 2'd1;
              bundle.res[0].data = cp_upd[7:0];
            end else if (cp_upd[15:11] == 5'd0) begin
              bundle.n           = 2'd2;
              bundle.res[0].data = jsu_pkg::UTF8_LEAD2 | {3'd0, cp_upd[10:6]};
              bundle.res[1].data = jsu_pkg::UTF8_CONT | {2'd0, cp_upd[5:0]};
            end else begin
              bundle.n           = 2'd3;
              bundle.res[0].data = jsu_pkg::UTF8_LEAD3 | {4'd0, cp_upd[15:12]};
              bundle.res[1].data = jsu_pkg::UTF8_CONT | {2'd0, cp_upd[11:6]};
              bundle.res[2].data = jsu_pkg::UTF8_CONT | {2'd0, cp_upd[5:0]};
            end
            st_nxt.mode        = jsu_pkg::MODE_BODY;
            st_nxt.hex_count   = 2'd0;
            st_nxt.code_point  = 16'd0;
            st_nxt.hex_stopped = 1'b0;
          end else begin
            st_nxt.hex_count = st_r.hex_count + 2'd1;
          end
        end
      end

      jsu_pkg::MODE_DROP: begin
        // Rest of a malformed literal: consumed silently.
      end

      default: begin
        // Awaiting the opening quote.
        if (s1_byte != jsu_pkg::CH_QUOTE || s1_last) begin
          bad = 1'b1;
        end else begin
          st_nxt.mode = jsu_pkg::MODE_BODY;
        end
      end
    endcase

    // Malformed literal: a single error result, nothing before it.
    if (bad) begin
      bundle.n             = 2'd1;
      bundle.res[0].data   = 8'd0;
      bundle.res[0].status = jsu_pkg::ST_BAD;
    end

    if (s1_last) begin
      st_nxt = jsu_pkg::STATE_RESET;
    end else if (bad) begin
      st_nxt.mode = jsu_pkg::MODE_DROP;
    end
  end

  // An item with no result never waits for the result buffer.
  assign adv  = s1_valid && (bundle.n == 2'd0 || buf_free);
  assign load = s1_valid && (bundle.n != 2'd0) && buf_free;

  // State register, updated as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= jsu_pkg::STATE_RESET;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: design/jsu_outbuf.sv
// Result buffer: holds the results of one item and hands them out one per
// cycle on the byte-wide result channel while it does not stall. Depends on jsu_pkg.
module jsu_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jsu_pkg::jsu_bundle_t bundle,
  output logic                 buf_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic [1:0]           out_status,
  output logic                 out_run_last
);

  jsu_pkg::jsu_result_t [2:0] res_r;
  logic [1:0]                 n_r;
  logic [1:0]                 idx_r;
  logic                       valid_r;
  logic                       at_end;
  logic                       take;
  jsu_pkg::jsu_result_t       cur;

  // Entry on show and whether it is the item's final result.
  always_comb begin
    unique case (idx_r)
      2'd0:    cur = res_r[0];
      2'd1:    cur = res_r[1];
      default: cur = res_r[2];
    endcase
  end

  assign at_end   = (idx_r == n_r - 2'd1);
  assign take     = valid_r && !out_stall;
  assign buf_free = !valid_r || (take && at_end);

  assign out_valid    = valid_r;
  assign out_byte     = cur.data;
  assign out_status   = cur.status;
  assign out_run_last = at_end;

  // Payload: loaded whole when the previous item's results are gone.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
      n_r   <= bundle.n;
    end
  end

  // Control: occupancy and read position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take) begin
      if (at_end) begin
        valid_r <= 1'b0;
        idx_r   <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

// File: design/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on json_string_unescape_utf8_top_defines.svh and jsu_pkg.
`include "json_string_unescape_utf8_top_defines.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_run_last
);

  logic status_known;
  logic status_item;

  // Classification of the status on show.
  assign status_known = (out_status == jsu_pkg::ST_DATA) ||
                        (out_status == jsu_pkg::ST_GOOD) ||
                        (out_status == jsu_pkg::ST_BAD);
  assign status_item  = (out_status != jsu_pkg::ST_DATA);

  // A result offered and stalled is still offered in the next cycle.
  `JSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result withdrawn while stalled")

  // Only the three defined status codes appear.
  `JSU_ASSERT_NOW(a_status_code, out_valid, status_known, "undefined status code")

  // A literal's status result is always the final result of its item.
  `JSU_ASSERT_NOW(a_status_last, out_valid && status_item, out_run_last, "status not marked final")

  // No result is offered straight after reset.
  `JSU_ASSERT_NEXT_NR(a_reset_idle, !rst_n, !out_valid, "result item offered after reset")

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_run_last (out_run_last)
);
